/* hw/rtl/mowm_pkg.sv */
package mowm_pkg;

  localparam int NUM_OSCILLATORS = 4;
  localparam int SINE_TABLE_BITS = 10;

  localparam int TABLE_N    = 1 << SINE_TABLE_BITS;
  localparam int ROM_ADDR_W = SINE_TABLE_BITS + 1;
  localparam int MAG_W      = 15;
  localparam int SAMPLE_W   = 32;
  localparam int PHASE_W    = 24;
  localparam int WAVE_W     = 16;
  // The most negative amplitude times a -1.0 wave reaches +2^29, one bit past 30 signed bits
  localparam int PROD_W     = 31;
  localparam int ACC_W      = PROD_W + $clog2(NUM_OSCILLATORS) + 1;
  localparam int VALUE_W    = 28;
  localparam int ROUND_SHIFT = 6;

  localparam logic signed [WAVE_W-1:0] ONE_Q14 = 16'sd16384;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // APB register window: one 64-bit register per oscillator at 8*i
  localparam int APB_DATA_W = 64;
  localparam int IDX_W      = (NUM_OSCILLATORS > 1) ? $clog2(NUM_OSCILLATORS) : 1;
  localparam int PADDR_W    = IDX_W + 3;

  typedef enum logic [2:0] {
    WAVE_SINE     = 3'd0,
    WAVE_SQUARE   = 3'd1,
    WAVE_TRIANGLE = 3'd2,
    WAVE_SAW      = 3'd3,
    WAVE_CONSTANT = 3'd4
  } wave_t;

  // Bit layout matches the register: enable at 51 down to frequency at 15..0
  typedef struct packed {
    logic                     enable;
    logic [2:0]               wave;
    logic signed [15:0]       amp;
    logic [15:0]              offset;
    logic [15:0]              freq;
  } osc_cfg_t;

  localparam int CFG_W = $bits(osc_cfg_t);

  // Item travelling down the chain: its time and the running sum
  typedef struct packed {
    logic [SAMPLE_W-1:0]      sample_time;
    logic signed [ACC_W-1:0]  acc;
  } link_t;

  typedef logic [MAG_W-1:0] sine_rom_t [0:TABLE_N];

  // Shift-and-subtract quotient, only evaluated while the table is built
  function automatic longint unsigned quot_u64(longint unsigned n, longint unsigned d);
    longint unsigned q;
    longint unsigned rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], n[b]};
      if (rem >= d) begin
        rem  = rem - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Quarter-wave table in Q1.14, built at elaboration from a Q30 series
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t         rom;
    longint unsigned   x;
    longint unsigned   term;
    longint unsigned   r;
    longint            s;
    int                i;
    int                k;
    for (i = 0; i <= TABLE_N; i++) begin
      x = (longint'(i) * HALF_PI_Q30) >> SINE_TABLE_BITS;
      term = x;
      s = longint'(x);
      for (k = 1; k <= 8; k++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = quot_u64(term, longint'((2 * k) * (2 * k + 1)));
        if (k[0]) begin
          s = s - longint'(term);
        end else begin
          s = s + longint'(term);
        end
      end
      if (s < 0) begin
        s = 0;
      end
      r = (longint'(s) + 32768) >> 16;
      if (r > 16384) begin
        r = 16384;
      end
      rom[i] = r[MAG_W-1:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

/* hw/rtl/mowm_cfg_regs.sv */
module mowm_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mowm_pkg::PADDR_W-1:0]        paddr,
  input  logic [mowm_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [mowm_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  output mowm_pkg::osc_cfg_t                  osc_cfg [mowm_pkg::NUM_OSCILLATORS]
);

  mowm_pkg::osc_cfg_t              regs_r [mowm_pkg::NUM_OSCILLATORS];
  logic [mowm_pkg::IDX_W-1:0]      idx;
  logic                            idx_ok;
  logic                            wr_en;

  assign idx    = paddr[mowm_pkg::PADDR_W-1:3];
  assign idx_ok = ((mowm_pkg::IDX_W + 1)'(idx) <
                   (mowm_pkg::IDX_W + 1)'(mowm_pkg::NUM_OSCILLATORS));
  assign wr_en  = psel && penable && pwrite && idx_ok;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mowm_pkg::NUM_OSCILLATORS; i++) begin
        regs_r[i] <= '0;
      end
    end else if (wr_en) begin
      regs_r[idx] <= mowm_pkg::osc_cfg_t'(pwdata[mowm_pkg::CFG_W-1:0]);
    end
  end

  always_comb begin
    prdata = '0;
    if (idx_ok) begin
      prdata = mowm_pkg::APB_DATA_W'(regs_r[idx]);
    end
  end

  always_comb begin
    for (int i = 0; i < mowm_pkg::NUM_OSCILLATORS; i++) begin
      osc_cfg[i] = regs_r[i];
    end
  end

endmodule

/* hw/rtl/mowm_cell.sv */
module mowm_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mowm_pkg::osc_cfg_t   cfg,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mowm_pkg::link_t      in_link,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mowm_pkg::link_t      out_link
);

  // Four stages: phase, wave lookup, amplitude multiply, accumulate
  logic                                   p_valid_r;
  mowm_pkg::link_t                        p_link_r;
  logic [mowm_pkg::PHASE_W-1:0]           p_c_r;

  logic                                   w_valid_r;
  mowm_pkg::link_t                        w_link_r;
  logic [mowm_pkg::MAG_W-1:0]             w_mag_r;
  logic                                   w_neg_r;
  logic                                   w_sine_r;
  logic signed [mowm_pkg::WAVE_W-1:0]     w_other_r;

  logic                                   m_valid_r;
  mowm_pkg::link_t                        m_link_r;
  logic signed [mowm_pkg::PROD_W-1:0]     m_prod_r;

  logic                                   a_valid_r;
  mowm_pkg::link_t                        a_link_r;

  logic en_p, en_w, en_m, en_a;

  assign en_a     = !a_valid_r || out_ready;
  assign en_m     = !m_valid_r || en_a;
  assign en_w     = !w_valid_r || en_m;
  assign en_p     = !p_valid_r || en_w;
  assign in_ready = en_p;

  // Phase: only the low 24 bits of freq*time survive the wrap
  logic [mowm_pkg::PHASE_W+15:0]          phase_prod;
  logic [mowm_pkg::PHASE_W-1:0]           c_nxt;

  assign phase_prod = cfg.freq * in_link.sample_time[mowm_pkg::PHASE_W-1:0];
  assign c_nxt      = phase_prod[mowm_pkg::PHASE_W-1:0] + {cfg.offset, 8'h00};

  // Wave shapes
  logic [1:0]                             quad;
  logic [mowm_pkg::SINE_TABLE_BITS-1:0]   tbl_idx;
  logic [mowm_pkg::ROM_ADDR_W-1:0]        rom_addr;
  logic [mowm_pkg::MAG_W-1:0]             mag_nxt;
  logic [mowm_pkg::PHASE_W-1:0]           tri_d;
  logic signed [mowm_pkg::WAVE_W:0]       tri_v;
  logic signed [mowm_pkg::WAVE_W-1:0]     saw_v;
  logic signed [mowm_pkg::WAVE_W-1:0]     other_nxt;
  logic                                   sine_nxt;

  assign quad     = p_c_r[mowm_pkg::PHASE_W-1 -: 2];
  assign tbl_idx  = p_c_r[mowm_pkg::PHASE_W-3 -: mowm_pkg::SINE_TABLE_BITS];
  assign rom_addr = quad[0] ?
                    mowm_pkg::ROM_ADDR_W'(mowm_pkg::TABLE_N) - {1'b0, tbl_idx} :
                    {1'b0, tbl_idx};
  assign mag_nxt  = mowm_pkg::SINE_ROM[rom_addr];

  assign tri_d = p_c_r[mowm_pkg::PHASE_W-1] ?
                 {1'b0, p_c_r[mowm_pkg::PHASE_W-2:0]} :
                 (mowm_pkg::PHASE_W'(1) << (mowm_pkg::PHASE_W - 1)) - p_c_r;
  assign tri_v = 17'sd16384 - $signed({1'b0, tri_d[mowm_pkg::PHASE_W-1:8]});
  assign saw_v = $signed({1'b0, p_c_r[mowm_pkg::PHASE_W-1:9]}) - mowm_pkg::ONE_Q14;

  always_comb begin
    other_nxt = '0;
    sine_nxt  = 1'b0;
    if (cfg.enable) begin
      case (cfg.wave)
        mowm_pkg::WAVE_SINE: begin
          sine_nxt = 1'b1;
        end
        mowm_pkg::WAVE_SQUARE: begin
          other_nxt = p_c_r[mowm_pkg::PHASE_W-1] ? -mowm_pkg::ONE_Q14 : mowm_pkg::ONE_Q14;
        end
        mowm_pkg::WAVE_TRIANGLE: begin
          other_nxt = tri_v[mowm_pkg::WAVE_W-1:0];
        end
        mowm_pkg::WAVE_SAW: begin
          other_nxt = saw_v;
        end
        mowm_pkg::WAVE_CONSTANT: begin
          other_nxt = mowm_pkg::ONE_Q14;
        end
        default: begin
          other_nxt = '0;
        end
      endcase
    end
  end

  // Amplitude scaling
  logic signed [mowm_pkg::WAVE_W-1:0]     wave_v;
  logic signed [2*mowm_pkg::WAVE_W-1:0]   prod_full;

  assign wave_v    = w_sine_r ?
                     (w_neg_r ? -$signed({1'b0, w_mag_r}) : $signed({1'b0, w_mag_r})) :
                     w_other_r;
  assign prod_full = $signed(cfg.amp) * wave_v;

  mowm_pkg::link_t                        a_link_nxt;

  always_comb begin
    a_link_nxt     = m_link_r;
    a_link_nxt.acc = m_link_r.acc + mowm_pkg::ACC_W'(m_prod_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
      w_valid_r <= 1'b0;
      m_valid_r <= 1'b0;
      a_valid_r <= 1'b0;
    end else begin
      if (en_p) p_valid_r <= in_valid;
      if (en_w) w_valid_r <= p_valid_r;
      if (en_m) m_valid_r <= w_valid_r;
      if (en_a) a_valid_r <= m_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_p) begin
      p_link_r <= in_link;
      p_c_r    <= c_nxt;
    end
    if (en_w) begin
      w_link_r  <= p_link_r;
      w_mag_r   <= mag_nxt;
      w_neg_r   <= quad[1];
      w_sine_r  <= sine_nxt;
      w_other_r <= other_nxt;
    end
    if (en_m) begin
      m_link_r <= w_link_r;
      m_prod_r <= prod_full[mowm_pkg::PROD_W-1:0];
    end
    if (en_a) begin
      a_link_r <= a_link_nxt;
    end
  end

  assign out_valid = a_valid_r;
  assign out_link  = a_link_r;

endmodule

/* hw/rtl/multi_oscillator_waveform_mixer.sv */
// Sums up to four oscillators (sine, square, triangle, saw, constant) at a
// given sample time. Oscillators are set through the APB port: one 64-bit
// register per oscillator at byte address 8*i, writes take effect at the
// access cycle, pready is always high and reads return the stored value.
// Input channel: in_sample_time (Q16.16) with in_valid/in_ready.
// Output channel: out_sample_value (signed Q11.16) with out_valid/out_ready,
// exactly one result per input transfer, in order.
// Each oscillator is one cell of four stages (phase, table lookup, multiply,
// accumulate); the running sum walks the chain, then a final register
// rounds it. Throughput is one transfer per cycle while out_ready holds;
// the per-cell phase multiplier and the registered sine table read bound
// the clock, not the rate.
// Every stage has its own valid bit and only stalls when the stage after it
// is full, so bubbles close up and input keeps flowing while a result waits.
// Reset (rst_n low, synchronous) empties the pipeline and clears all
// oscillator registers, which disables every oscillator.
module multi_oscillator_waveform_mixer (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [mowm_pkg::SAMPLE_W-1:0]         in_sample_time,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [mowm_pkg::VALUE_W-1:0]   out_sample_value,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [mowm_pkg::PADDR_W-1:0]          paddr,
  input  logic [mowm_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [mowm_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                  pready
);

  mowm_pkg::osc_cfg_t   osc_cfg [mowm_pkg::NUM_OSCILLATORS];

  mowm_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .osc_cfg (osc_cfg)
  );

  logic              chain_valid [mowm_pkg::NUM_OSCILLATORS+1];
  logic              chain_ready [mowm_pkg::NUM_OSCILLATORS+1];
  mowm_pkg::link_t   chain_link  [mowm_pkg::NUM_OSCILLATORS+1];

  assign chain_valid[0]            = in_valid;
  assign in_ready                  = chain_ready[0];
  assign chain_link[0].sample_time = in_sample_time;
  assign chain_link[0].acc         = '0;

  for (genvar g = 0; g < mowm_pkg::NUM_OSCILLATORS; g++) begin : g_cell
    mowm_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cfg       (osc_cfg[g]),
      .in_valid  (chain_valid[g]),
      .in_ready  (chain_ready[g]),
      .in_link   (chain_link[g]),
      .out_valid (chain_valid[g+1]),
      .out_ready (chain_ready[g+1]),
      .out_link  (chain_link[g+1])
    );
  end

  // Output register: round half up from Q.22 to Q11.16
  logic                                   out_valid_r;
  logic signed [mowm_pkg::VALUE_W-1:0]    out_value_r;
  logic signed [mowm_pkg::ACC_W-1:0]      rnd_sum;
  logic signed [mowm_pkg::ACC_W-1:0]      rnd_shift;
  logic signed [mowm_pkg::VALUE_W-1:0]    out_value_nxt;
  logic                                   out_en;

  assign out_en        = !out_valid_r || out_ready;
  assign chain_ready[mowm_pkg::NUM_OSCILLATORS] = out_en;
  assign rnd_sum       = chain_link[mowm_pkg::NUM_OSCILLATORS].acc +
                         mowm_pkg::ACC_W'(32);
  assign rnd_shift     = rnd_sum >>> mowm_pkg::ROUND_SHIFT;
  assign out_value_nxt = rnd_shift[mowm_pkg::VALUE_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_en) begin
      out_valid_r <= chain_valid[mowm_pkg::NUM_OSCILLATORS];
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      out_value_r <= out_value_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample_value = out_value_r;

endmodule
